/* hdl/lbp_pkg.sv */
// Shared types, widths and codes for the 3x3 LBP histogram block.
// No dependencies; imported by lbp_3x3_histogram, lbp_checker and the testbench.
`default_nettype none

package lbp_pkg;

  localparam int PIX_W          = 8;
  localparam int BIN_IDX_W      = 8;
  localparam int NUM_BINS       = 256;
  localparam int BIN_COUNT_W    = 20;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0]       CFG_DIM_RESET = 11'd1024;
  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_MAX = {BIN_COUNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // window[r*3+c]: r 0 top .. 2 bottom, c 0 left .. 2 right
  typedef logic [8:0][PIX_W-1:0] window_t;

  // Neighbors clockwise from top-left, strictly greater than the center.
  function automatic logic [7:0] lbp_pattern(window_t w);
    logic [7:0] pat;
    pat[0] = w[0] > w[4];
    pat[1] = w[1] > w[4];
    pat[2] = w[2] > w[4];
    pat[3] = w[5] > w[4];
    pat[4] = w[8] > w[4];
    pat[5] = w[7] > w[4];
    pat[6] = w[6] > w[4];
    pat[7] = w[3] > w[4];
    return pat;
  endfunction

endpackage

`default_nettype wire

/* hdl/lbp_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on an address collision. No dependencies.
`default_nettype none

module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/lbp_3x3_histogram.sv */
// 3x3 local binary pattern histogram, top level.
// Depends on lbp_pkg and lbp_ram (line store and histogram memories).
`default_nettype none

// One transaction per clock while in_ready is high, pixels and commands alike. Pixels
// stream in raster order; the two previous rows live in one line-store RAM read in the
// cycle before the window shift. Each interior pattern increments its bin by
// read-modify-write of the histogram RAM, one update per clock, with forwarding between
// back-to-back hits on one bin. A bin read passes through the s1, s2 and s3 registers into
// the 8-entry output queue and shows up on the output behind any earlier results still
// waiting; in_ready drops only while queued plus in-flight reads would fill that queue. The
// histogram clears at once on reset or a clear command (per-bin valid bits), so there is
// no clearing pass. Line-store contents are undefined until written.
module lbp_3x3_histogram
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [PIX_W-1:0]       pixel,
  input  logic [BIN_IDX_W-1:0]   bin_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BIN_IDX_W-1:0]   bin_number,
  output logic [BIN_COUNT_W-1:0] bin_count
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int RW        = $clog2(MAX_HEIGHT + 1);
  localparam int OUT_DEPTH = 8;
  localparam int QW        = $clog2(OUT_DEPTH);
  localparam int QCW       = $clog2(OUT_DEPTH + 1);
  localparam int HAW       = $clog2(NUM_BINS);

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                emit;
    logic [CW-1:0]       col;
    logic [PIX_W-1:0]    px;
    logic [BIN_IDX_W-1:0] bin;
  } s1_t;

  typedef struct packed {
    op_t            op;
    logic [HAW-1:0] addr;
  } hs_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0]   bin;
    logic [BIN_COUNT_W-1:0] count;
  } result_t;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_DIM_RESET;
      image_height <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (image_width < CFG_W'(3))              w_eff = WW'(3);
    else if (32'(image_width) > MAX_WIDTH)    w_eff = WW'(MAX_WIDTH);
    else                                      w_eff = WW'(image_width);
    if (image_height < CFG_W'(3))             h_eff = RW'(3);
    else if (32'(image_height) > MAX_HEIGHT)  h_eff = RW'(MAX_HEIGHT);
    else                                      h_eff = RW'(image_height);
  end

  // ---------------- stage 0: frame position, line-store read ----------------
  logic          accept, frame_open, push_go, col_last;
  logic [CW-1:0] col, col_fix;
  logic [RW-1:0] row;

  assign accept     = in_valid && in_ready;
  assign col_fix    = (WW'(col) >= w_eff) ? CW'(w_eff - WW'(1)) : col;
  assign col_last   = (WW'(col_fix) + WW'(1)) >= w_eff;
  assign frame_open = row < h_eff;
  assign push_go    = accept && (cmd == CMD_PUSH) && frame_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept && cmd == CMD_CLEAR) begin
      col <= '0;
      row <= '0;
    end else if (push_go) begin
      if (col_last) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col_fix + CW'(1);
      end
    end
  end

  logic                 s1_valid;
  s1_t                  s1;
  logic                 line_we;
  logic [2*PIX_W-1:0]   line_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= push_go || (accept && (cmd == CMD_READ || cmd == CMD_CLEAR));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_READ)       s1.op <= OP_READ;
    else if (cmd == CMD_CLEAR) s1.op <= OP_CLEAR;
    else                       s1.op <= OP_PUSH;
    s1.emit <= (row >= RW'(2)) && (col_fix >= CW'(2));
    s1.col  <= col_fix;
    s1.px   <= pixel;
    s1.bin  <= bin_index;
  end

  // [15:8] upper row, [7:0] middle row
  lbp_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1.col),
    .wdata ({line_rd[PIX_W-1:0], s1.px}),
    .raddr (col_fix),
    .rdata (line_rd)
  );

  // ---------------- stage 1: window shift, pattern ----------------
  window_t win, win_next;

  assign line_we = s1_valid && (s1.op == OP_PUSH);

  always_comb begin
    win_next = win;
    if (s1_valid && s1.op == OP_PUSH) begin
      for (int r = 0; r < 3; r++) begin
        win_next[r*3]   = win[r*3+1];
        win_next[r*3+1] = win[r*3+2];
      end
      win_next[2] = line_rd[2*PIX_W-1:PIX_W];
      win_next[5] = line_rd[PIX_W-1:0];
      win_next[8] = s1.px;
    end else if (s1_valid && s1.op == OP_CLEAR) begin
      win_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else begin
      win <= win_next;
    end
  end

  logic s2_valid, s3_valid;
  hs_t  s2, s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && (s1.op != OP_PUSH || s1.emit);
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2.op   <= s1.op;
    s2.addr <= (s1.op == OP_READ) ? s1.bin : lbp_pattern(win_next);
    s3      <= s2;
  end

  // ---------------- stages 2-3: histogram read-modify-write ----------------
  logic [NUM_BINS-1:0]    bin_valid;
  logic [BIN_COUNT_W-1:0] hist_rd, cur, inc;
  logic                   hist_we, fwd_valid, fwd_hit;
  logic [HAW-1:0]         fwd_addr;
  logic [BIN_COUNT_W-1:0] fwd_data;

  lbp_ram #(
    .WIDTH (BIN_COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (s3.addr),
    .wdata (inc),
    .raddr (s2.addr),
    .rdata (hist_rd)
  );

  // last cycle's write is not yet seen by a read issued alongside it
  assign fwd_hit = fwd_valid && (fwd_addr == s3.addr);
  assign cur     = fwd_hit ? fwd_data : (bin_valid[s3.addr] ? hist_rd : '0);
  assign inc     = (cur == BIN_COUNT_MAX) ? cur : cur + BIN_COUNT_W'(1);
  assign hist_we = s3_valid && (s3.op == OP_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (s3_valid && s3.op == OP_CLEAR) begin
      bin_valid <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= hist_we;
      if (hist_we) begin
        bin_valid[s3.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s3.addr;
    fwd_data <= inc;
  end

  // ---------------- output queue ----------------
  result_t        q_mem [OUT_DEPTH];
  logic [QW-1:0]  q_wptr, q_rptr;
  logic [QCW-1:0] q_count, reads_inflight;
  logic           q_push, q_pop;

  assign q_push = s3_valid && (s3.op == OP_READ);
  assign q_pop  = out_valid && out_ready;

  assign reads_inflight = QCW'(s1_valid && s1.op == OP_READ)
                        + QCW'(s2_valid && s2.op == OP_READ)
                        + QCW'(s3_valid && s3.op == OP_READ);
  assign in_ready  = (q_count + reads_inflight) < QCW'(OUT_DEPTH);
  assign out_valid = q_count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) q_wptr <= q_wptr + QW'(1);
      if (q_pop)  q_rptr <= q_rptr + QW'(1);
      case ({q_push, q_pop})
        2'b10:   q_count <= q_count + QCW'(1);
        2'b01:   q_count <= q_count - QCW'(1);
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wptr] <= '{bin: s3.addr, count: cur};
    end
  end

  assign bin_number = q_mem[q_rptr].bin;
  assign bin_count  = q_mem[q_rptr].count;

endmodule

`default_nettype wire

/* hdl/lbp_checker.sv */
// Port-level assertions for lbp_3x3_histogram, with the bind that attaches them.
// Depends on lbp_pkg and the top level's port names.
`default_nettype none

module lbp_checker
  import lbp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [1:0]             cmd,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [BIN_IDX_W-1:0]   bin_number,
  input logic [BIN_COUNT_W-1:0] bin_count
);

  // reset empties the output queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_number) && $stable(bin_count))
    else $error("stalled result changed");

  // a result appearing on an empty output comes from a read accepted earlier and carried through s1, s2 and s3
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && cmd == CMD_READ, 4))
    else $error("result without a matching read transaction");

  // with the output drained, the input side is never held off
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && out_ready |=> in_ready)
    else $error("input stalled with an empty output");

endmodule

bind lbp_3x3_histogram lbp_checker u_lbp_checker (.*);

`default_nettype wire

/* tb/sv/tb_lbp_3x3_histogram.sv */
`timescale 1ns / 1ps
// Testbench for lbp_3x3_histogram: directed stimulus table, then randomized frames
// with bursty input and a stalling consumer, checked against an in-bench LBP predictor.
// Depends on lbp_pkg and the lbp_3x3_histogram RTL.
module tb_lbp_3x3_histogram;
  import lbp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_DIM = 1024;
  localparam int TARGET_ITEMS = 750;
  localparam int EXTREME_ITEMS = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int DIRECTED_LEN = 25;
  // window slot of each pattern bit, bit 0 (top-left) clockwise to bit 7 (left)
  localparam logic [7:0][3:0] NBR_SLOT = {4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0};

  typedef struct packed {
    logic [BIN_IDX_W-1:0]   bin;
    logic [BIN_COUNT_W-1:0] count;
  } bin_read_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [PIX_W-1:0]       pix;
    logic [BIN_IDX_W-1:0]   bin;
    logic                   typed;
    logic [BIN_COUNT_W-1:0] count;
  } stim_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             cmd = CMD_PUSH;
  logic [PIX_W-1:0]       pixel = '0;
  logic [BIN_IDX_W-1:0]   bin_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [BIN_IDX_W-1:0]   bin_number;
  logic [BIN_COUNT_W-1:0] bin_count;

  lbp_3x3_histogram u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pixel      (pixel),
    .bin_index  (bin_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bin_number (bin_number),
    .bin_count  (bin_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state
  logic [CFG_W-1:0]       width_reg;
  logic [CFG_W-1:0]       height_reg;
  logic [PIX_W-1:0]       upper_line [MAX_DIM];
  logic [PIX_W-1:0]       middle_line [MAX_DIM];
  window_t                win;
  int unsigned            col_pos;
  int unsigned            row_pos;
  logic [BIN_COUNT_W-1:0] hist [NUM_BINS];
  logic [7:0]             recent_patterns [$];
  bin_read_t              expected_reads [$];

  int mismatches = 0;
  int random_items = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  stim_row_t directed_rows [DIRECTED_LEN] = '{
    '{CMD_READ,   8'd0,   8'd0,   1'b1, 20'd0},   // empty histogram after reset
    '{CMD_UNUSED, 8'hFF,  8'hFF,  1'b0, 20'd0},
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd100, 8'd0,   1'b0, 20'd0},   // dark center: all bits set
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd200, 8'd0,   1'b0, 20'd0},
    '{CMD_READ,   8'd0,   8'd255, 1'b1, 20'd1},
    '{CMD_PUSH,   8'd0,   8'd0,   1'b0, 20'd0},   // past the frame end, dropped
    '{CMD_CLEAR,  8'd0,   8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd0,   8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd255, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd0,   8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd255, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd128, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd0,   8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd255, 8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd0,   8'd0,   1'b0, 20'd0},
    '{CMD_PUSH,   8'd255, 8'd0,   1'b0, 20'd0},
    '{CMD_READ,   8'd0,   8'd210, 1'b0, 20'd0},
    '{CMD_READ,   8'd0,   8'd255, 1'b1, 20'd0}    // cleared bin
  };

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] raw);
    if (raw < 3) return 3;
    if (raw > MAX_DIM) return MAX_DIM;
    return 32'(raw);
  endfunction

  function automatic bit frame_done();
    return row_pos >= eff_dim(height_reg);
  endfunction

  task automatic restart_frame();
    win = '0;
    col_pos = 0;
    row_pos = 0;
    foreach (hist[i]) hist[i] = '0;
  endtask

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Advance the predictor state by one accepted transaction.
  task automatic track_txn(logic [1:0] op, logic [PIX_W-1:0] px, logic [BIN_IDX_W-1:0] b,
                           logic typed, logic [BIN_COUNT_W-1:0] count);
    int unsigned w;
    int unsigned c;
    int r;
    int k;
    logic [7:0] pat;
    bin_read_t exp_read;
    case (op)
      CMD_PUSH: begin
        w = eff_dim(width_reg);
        if (!frame_done()) begin
          c = (col_pos >= w) ? w - 1 : col_pos;
          for (r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
          end
          win[2] = upper_line[c];
          win[5] = middle_line[c];
          win[8] = px;
          upper_line[c] = middle_line[c];
          middle_line[c] = px;
          if (row_pos >= 2 && c >= 2) begin
            for (k = 0; k < 8; k++) pat[k] = win[NBR_SLOT[k]] > win[4];
            if (hist[pat] != BIN_COUNT_MAX) hist[pat] = hist[pat] + 1'b1;
            recent_patterns = {recent_patterns, pat};
            if (recent_patterns.size() > 32) void'(recent_patterns.pop_front());
          end
          if (c + 1 >= w) begin
            col_pos = 0;
            row_pos++;
          end else begin
            col_pos = c + 1;
          end
        end
      end
      CMD_READ: begin
        exp_read.bin = b;
        exp_read.count = typed ? count : hist[b];
        expected_reads = {expected_reads, exp_read};
      end
      CMD_CLEAR: restart_frame();
      default: ;
    endcase
  endtask

  task automatic send_txn(logic [1:0] op, logic [PIX_W-1:0] px, logic [BIN_IDX_W-1:0] b,
                          logic typed = 1'b0, logic [BIN_COUNT_W-1:0] count = '0);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 150);
      else burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    cmd <= op;
    pixel <= px;
    bin_index <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    track_txn(op, px, b, typed, count);
  endtask

  task automatic drain_reads();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_reads.size() != 0) @(posedge clk);
    // histogram updates from the last pixels may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
    height_reg = h;
  endtask

  task automatic start_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    bit must_clear;
    drain_reads();
    // widening mid-frame would pull never-written line-store columns into a window
    must_clear = (eff_dim(w) > eff_dim(width_reg)) && (row_pos != 0 || col_pos != 0);
    write_dims(w, h);
    if (must_clear || frame_done() || $urandom_range(0, 2) == 0)
      send_txn(CMD_CLEAR, PIX_W'($urandom_range(0, 255)), BIN_IDX_W'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(int n_items, int push_pct, int pix_mode);
    int done_items;
    int r;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] px;
    logic [BIN_IDX_W-1:0] b;
    base = PIX_W'($urandom_range(0, 252));
    done_items = 0;
    while (done_items < n_items) begin
      r = $urandom_range(0, 99);
      case (pix_mode)
        0: px = PIX_W'($urandom_range(0, 255));
        1: px = PIX_W'(base + $urandom_range(0, 3));   // lots of ties with the center
        default: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      if (recent_patterns.size() != 0 && $urandom_range(0, 1))
        b = recent_patterns[$urandom_range(0, recent_patterns.size() - 1)];
      else
        b = BIN_IDX_W'($urandom_range(0, 255));
      if (frame_done()) begin
        if (r < 40) begin
          send_txn(CMD_READ, px, b);
          done_items++;
        end else if (r < 70) begin
          send_txn(CMD_PUSH, px, b);
        end else begin
          send_txn(CMD_CLEAR, px, b);
          done_items++;
        end
      end else if (r < push_pct) begin
        send_txn(CMD_PUSH, px, b);
        done_items++;
      end else if (r < 97) begin
        send_txn(CMD_READ, px, b);
        done_items++;
      end else if (r < 99 && push_pct < 90) begin
        send_txn(CMD_CLEAR, px, b);
        done_items++;
      end else begin
        send_txn(CMD_UNUSED, px, b);
      end
    end
    random_items += done_items;
  endtask

  initial begin : receiver
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_reads
    bin_read_t exp_read;
    if (!rst && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        log_mismatch($sformatf("unexpected bin read: bin %0d count %0d",
                               bin_number, bin_count));
      end else begin
        exp_read = expected_reads.pop_front();
        if (exp_read.bin !== bin_number || exp_read.count !== bin_count)
          log_mismatch($sformatf(
            "bin read mismatch: expected bin %0d count %0d, got bin %0d count %0d",
            exp_read.bin, exp_read.count, bin_number, bin_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] w_raw;
    logic [CFG_W-1:0] h_raw;
    width_reg = CFG_DIM_RESET;
    height_reg = CFG_DIM_RESET;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    restart_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_dims(11'd0, 11'd1);   // both clamp up to 3
    foreach (directed_rows[i])
      send_txn(directed_rows[i].op, directed_rows[i].pix, directed_rows[i].bin,
               directed_rows[i].typed, directed_rows[i].count);

    // oversize width, then oversize height, each clamped to its maximum; the other dimension stays small
    start_phase(11'd2047, 11'd3);
    run_phase(EXTREME_ITEMS, 97, 0);
    start_phase(11'd0, 11'd2047);
    run_phase(EXTREME_ITEMS, 97, 1);

    random_items = 0;
    while (random_items < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 5))
          0: w_raw = 11'd0;
          1: w_raw = 11'd1;
          2: w_raw = 11'd2;
          3: w_raw = 11'd1024;
          4: w_raw = 11'd1025;
          default: w_raw = 11'd2047;
        endcase
      end else begin
        w_raw = CFG_W'($urandom_range(3, 20));
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: h_raw = 11'd0;
          1: h_raw = 11'd1;
          2: h_raw = 11'd2;
          default: h_raw = 11'd2047;
        endcase
      end else begin
        h_raw = CFG_W'($urandom_range(3, 12));
      end
      start_phase(w_raw, h_raw);
      run_phase($urandom_range(40, 160), $urandom_range(70, 88), $urandom_range(0, 2));
    end

    drain_reads();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lbp_pkg.sv
hdl/lbp_ram.sv
hdl/lbp_3x3_histogram.sv
hdl/lbp_checker.sv
tb/sv/tb_lbp_3x3_histogram.sv
